FILE: hdl/imr_pkg.sv
// ----------------------------------------------------------------------------
// imr_pkg
// Shared sizes for the interrupt moderation scanner: context count, index
// widths and stream word layouts.
// ----------------------------------------------------------------------------
package imr_pkg;

    // Number of moderated contexts
    localparam int NUM_CONTEXTS = 32;

    // Context index width inside the block
    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    // Width of the context number carried on the stream ports
    localparam int REQ_W = 5;

    // Timestamp and interval width
    localparam int TS_W = 64;

    // Index width that holds both the stream context number and the count
    localparam int IDX_W = ((CTX_W > REQ_W) ? CTX_W : REQ_W) + 1;

    // Input word: context_req [4:0], timestamp [68:5], zero fill to bytes
    localparam int S_TDATA_BITS = REQ_W + TS_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;

    // Output word: interrupt [0], served_context [5:1], zero fill to bytes
    localparam int M_TDATA_BITS = 1 + REQ_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    // Action codes carried in s_tuser
    localparam logic ACT_MARK = 1'b0;
    localparam logic ACT_POLL = 1'b1;

endpackage

FILE: hdl/interrupt_moderation_scanner.sv
// ----------------------------------------------------------------------------
// interrupt_moderation_scanner
// Per-context interrupt moderation with a minimum interval between two
// interrupts of one context, served by a round-robin poll pointer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per item. s_tuser is the action (0 mark, 1 poll),
//   s_tdata carries context_req and the poll timestamp.
//   m_ channel: exactly one word per input word, in order, with the
//   interrupt flag and the served context.
//   cfg channel: writes min_interval; cfg_ready is always high. Write it
//   only while no item is in flight.
//   Result path: the edge that takes an input word does the last-notify
//   RAM read into the read stage; the update and the output register
//   follow when the read stage advances into a free output slot.
//   Throughput: one word per cycle while m_tready stays high; the RAM
//   read-modify-write of the last-notify times sets it, with forwarding
//   of a write to the entry being read in the same cycle.
//   Reset: activity flags, written marks, scan pointer and min_interval
//   clear at once; the RAM needs no clearing pass, since an entry never
//   written reads as zero through its written mark.
//   Stall: while m_tready is low the result holds and one more item can
//   still be taken into the read stage; then s_tready drops.
// ----------------------------------------------------------------------------
module interrupt_moderation_scanner (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [imr_pkg::S_TDATA_W-1:0]  s_tdata,   // [4:0] context_req, [68:5] timestamp
    input  logic                           s_tuser,   // [0] action
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [imr_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] interrupt, [5:1] served_context
    // Configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [imr_pkg::TS_W-1:0]       cfg_data   // min_interval
);

    import imr_pkg::*;

    // Configuration
    logic [TS_W-1:0]         min_interval_reg;

    // Context state in flip-flops
    logic [NUM_CONTEXTS-1:0] flags_reg, flags_next;
    logic [NUM_CONTEXTS-1:0] written_reg, written_next;
    logic [CTX_W-1:0]        ptr_reg, ptr_next;

    // Read stage
    logic                    st_valid_reg;
    logic                    st_action_reg;
    logic [REQ_W-1:0]        st_req_reg;
    logic [TS_W-1:0]         st_ts_reg;
    logic [CTX_W-1:0]        st_idx_reg;
    logic                    st_written_reg;
    logic                    st_bypass_reg;
    logic [TS_W-1:0]         st_bypass_data_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_irq_reg;
    logic [REQ_W-1:0]        out_ctx_reg;

    // Handshake and datapath
    logic                    s_accept;
    logic                    advance;
    logic [REQ_W-1:0]        in_req;
    logic [TS_W-1:0]         in_ts;
    logic [IDX_W-1:0]        ptr_inc;
    logic [IDX_W-1:0]        req_ext;
    logic                    req_in_range;
    logic [TS_W-1:0]         ram_rd_data;
    logic [TS_W-1:0]         last_time;
    logic [TS_W-1:0]         elapsed;
    logic                    flag_hit;
    logic                    fire;
    logic                    ram_wr_en;
    logic                    bypass_now;
    logic                    res_irq;
    logic [REQ_W-1:0]        res_ctx;

    // Unpack the input word
    assign in_req = s_tdata[REQ_W-1:0];
    assign in_ts  = s_tdata[REQ_W +: TS_W];

    // Stage moves on when the output slot is free or being drained
    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // Last notify time store
    imr_ram #(
        .WIDTH (TS_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_last_time (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (st_idx_reg),
        .wr_data (st_ts_reg),
        .rd_en   (s_accept),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Pick the stored time: forwarded write, RAM data, or zero if never written
    always_comb begin
        if (st_bypass_reg) begin
            last_time = st_bypass_data_reg;
        end else if (st_written_reg) begin
            last_time = ram_rd_data;
        end else begin
            last_time = '0;
        end
    end

    // Poll decision
    assign elapsed   = st_ts_reg - last_time;
    assign flag_hit  = flags_reg[st_idx_reg];
    assign fire      = flag_hit && (elapsed >= min_interval_reg);
    assign ram_wr_en = advance && (st_action_reg == ACT_POLL) && fire;

    // Forward a write that lands on the entry read in the same cycle
    assign bypass_now = ram_wr_en && (st_idx_reg == ptr_reg);

    // Mark range check
    assign req_ext      = IDX_W'(st_req_reg);
    assign req_in_range = req_ext < IDX_W'(NUM_CONTEXTS);

    function automatic logic [REQ_W-1:0] req_from_idx(input logic [CTX_W-1:0] idx);
        logic [IDX_W-1:0] wide;
        wide = IDX_W'(idx);
        return wide[REQ_W-1:0];
    endfunction

    // Result fields
    always_comb begin
        if (st_action_reg == ACT_POLL) begin
            res_irq = fire;
            res_ctx = req_from_idx(st_idx_reg);
        end else begin
            res_irq = 1'b0;
            res_ctx = st_req_reg;
        end
    end

    // Next flag, written-mark and pointer state
    always_comb begin
        flags_next   = flags_reg;
        written_next = written_reg;
        ptr_next     = ptr_reg;
        ptr_inc      = IDX_W'(ptr_reg) + IDX_W'(1);
        if (advance) begin
            if (st_action_reg == ACT_MARK) begin
                if (req_in_range) begin
                    flags_next[req_ext[CTX_W-1:0]] = 1'b1;
                end
            end else begin
                flags_next[st_idx_reg] = 1'b0;
            end
        end
        if (ram_wr_en) begin
            written_next[st_idx_reg] = 1'b1;
        end
        if (s_accept && (s_tuser == ACT_POLL)) begin
            if (ptr_inc >= IDX_W'(NUM_CONTEXTS)) begin
                ptr_next = '0;
            end else begin
                ptr_next = ptr_inc[CTX_W-1:0];
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= '0;
            flags_reg        <= '0;
            written_reg      <= '0;
            ptr_reg          <= '0;
            st_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_interval_reg <= cfg_data;
            end
            flags_reg   <= flags_next;
            written_reg <= written_next;
            ptr_reg     <= ptr_next;
            if (s_accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read stage payload: capture the item and forwarding info
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_action_reg      <= s_tuser;
            st_req_reg         <= in_req;
            st_ts_reg          <= in_ts;
            st_idx_reg         <= ptr_reg;
            st_written_reg     <= written_reg[ptr_reg] || bypass_now;
            st_bypass_reg      <= bypass_now;
            st_bypass_data_reg <= st_ts_reg;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_irq_reg <= res_irq;
            out_ctx_reg <= res_ctx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_ctx_reg, out_irq_reg});

endmodule

FILE: hdl/imr_ram.sv
// ----------------------------------------------------------------------------
// imr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/imr_checker.sv
// ----------------------------------------------------------------------------
// imr_checker
// Port-level checks for the interrupt moderation scanner, bound to the top.
// ----------------------------------------------------------------------------
module imr_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [imr_pkg::M_TDATA_W-1:0]  m_tdata
);

    import imr_pkg::*;

    // Words taken but not yet delivered
    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
        end
    end

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Drop the result after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Deliver only words that were taken
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result word without a pending input");

    // Keep at most read stage plus output in flight
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 && !m_tready |-> !s_tready)
        else $error("input taken with no room left");

endmodule

bind interrupt_moderation_scanner imr_checker u_imr_checker (.*);

FILE: sim/tb_interrupt_moderation_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_moderation_scanner
// Self-checking bench for the interrupt moderation scanner. Drives mark and
// poll words with random gaps and output stalls. Predicts each result word
// from a local copy of the activity flags, last-notify times, scan pointer
// and interval. Checks results in order, field by field.
// ----------------------------------------------------------------------------
module tb_interrupt_moderation_scanner;

    import imr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic             irq;
        logic [REQ_W-1:0] ctx;
    } irq_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [4:0] context_req, [68:5] timestamp
    logic                 s_tuser;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] interrupt, [5:1] served_context
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TS_W-1:0]      cfg_data;

    // Local copy of the block state
    logic [TS_W-1:0] interval_reg;
    logic [TS_W-1:0] ctx_last [NUM_CONTEXTS];
    bit              ctx_flag [NUM_CONTEXTS];
    int unsigned     scan_idx;

    irq_word_t   pending_q[$];
    int unsigned err_count;
    int unsigned n_items, n_polls, n_irq, n_quiet, n_cfg;

    // Stimulus controls shared by the sender, the ready process and run_mix
    bit              tx_idle_en;
    bit              rx_stall_en;
    bit              rx_hold_req;
    logic [TS_W-1:0] wall_ts;

    interrupt_moderation_scanner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Clear the local state as the block does on reset
    task automatic reset_model();
        interval_reg = '0;
        for (int k = 0; k < NUM_CONTEXTS; k++) begin
            ctx_last[k] = '0;
            ctx_flag[k] = 1'b0;
        end
        scan_idx = 0;
    endtask

    // Apply one accepted word to the local state and return its result
    function automatic irq_word_t moderate(logic act, logic [REQ_W-1:0] req,
                                           logic [TS_W-1:0] now);
        irq_word_t   r;
        int unsigned cur;
        r.irq = 1'b0;
        n_items++;
        if (act == ACT_MARK) begin
            if (req < NUM_CONTEXTS)
                ctx_flag[req] = 1'b1;
            r.ctx = req;
        end else begin
            n_polls++;
            cur = (scan_idx >= NUM_CONTEXTS) ? 0 : scan_idx;
            r.ctx = cur[REQ_W-1:0];
            if (ctx_flag[cur]) begin
                // The flag drops even when the interval holds the interrupt back
                ctx_flag[cur] = 1'b0;
                if (now - ctx_last[cur] >= interval_reg) begin
                    r.irq = 1'b1;
                    ctx_last[cur] = now;
                    n_irq++;
                end else begin
                    n_quiet++;
                end
            end
            scan_idx = (cur + 1 >= NUM_CONTEXTS) ? 0 : cur + 1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    // Track config writes, check result words, predict accepted input words
    always @(posedge aclk) begin : monitor
        irq_word_t want;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                interval_reg = cfg_data;
                n_cfg++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", 64'd0,
                                    64'(m_tdata));
                end else begin
                    want = pending_q.pop_front();
                    if (m_tdata[0] !== want.irq)
                        report_mismatch("interrupt", 64'(want.irq), 64'(m_tdata[0]));
                    if (m_tdata[REQ_W:1] !== want.ctx)
                        report_mismatch("served_context", 64'(want.ctx),
                                        64'(m_tdata[REQ_W:1]));
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(moderate(s_tuser, s_tdata[REQ_W-1:0],
                                             s_tdata[REQ_W +: TS_W]));
        end
    end

    // End the run when no word moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    // Output ready: random stalls, plus one long hold on request
    initial begin : ready_proc
        int unsigned n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one word and return at the edge where it is taken
    task automatic send_item(logic act, logic [REQ_W-1:0] ctx, logic [TS_W-1:0] ts);
        logic [S_TDATA_W-1:0] w;
        int unsigned          gap;
        @(negedge aclk);
        gap = (tx_idle_en && $urandom_range(0, 4) < 2) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        w = '0;
        w[REQ_W-1:0]    = ctx;
        w[REQ_W +: TS_W] = ts;
        s_tdata  <= w;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_q.size() != 0)
            @(posedge aclk);
    endtask

    // Write the interval only with nothing in flight
    task automatic set_interval(logic [TS_W-1:0] v);
        idle_sender();
        wait_drain();
        repeat (3) @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random marks and polls; polls follow a running clock with some noise
    task automatic run_mix(int unsigned count, int unsigned step_max);
        logic [TS_W-1:0] ts;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 1)) begin
                wall_ts += TS_W'($urandom_range(0, step_max));
                ts = ($urandom_range(0, 11) == 0) ? {$urandom, $urandom} : wall_ts;
                send_item(ACT_POLL, REQ_W'($urandom_range(0, 31)), ts);
            end else begin
                send_item(ACT_MARK, REQ_W'($urandom_range(0, 31)), {$urandom, $urandom});
            end
        end
    endtask

    // Reset defaults: zero interval, repeated marks, poll of a clear context
    task automatic test_reset_defaults();
        send_item(ACT_POLL, 5'd31, '0);
        send_item(ACT_MARK, 5'd31, '1);
        send_item(ACT_MARK, 5'd0, '0);
        send_item(ACT_MARK, 5'd1, '0);
        send_item(ACT_MARK, 5'd1, '1);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_MARK, 5'd2, '0);
        send_item(ACT_POLL, 5'd2, '1);
        send_item(ACT_POLL, 5'd0, 64'h5555_5555_5555_5555);
    endtask

    // Full-scale interval: only a difference of all ones passes
    task automatic test_max_interval();
        int unsigned c;
        set_interval('1);
        wait_drain();
        c = scan_idx;
        send_item(ACT_MARK, c[REQ_W-1:0], '0);
        send_item(ACT_POLL, '0, ctx_last[c] - 64'd2);
        c = (c + 1) % NUM_CONTEXTS;
        send_item(ACT_MARK, c[REQ_W-1:0], '0);
        send_item(ACT_POLL, '0, ctx_last[c] - 64'd1);
    endtask

    // Interval of one: equal timestamp held back, a timestamp one later passes
    task automatic test_unit_interval();
        int unsigned c;
        set_interval(64'd1);
        wait_drain();
        c = scan_idx;
        send_item(ACT_MARK, c[REQ_W-1:0], '0);
        send_item(ACT_POLL, '0, ctx_last[c]);
        c = (c + 1) % NUM_CONTEXTS;
        send_item(ACT_MARK, c[REQ_W-1:0], '0);
        send_item(ACT_POLL, '0, ctx_last[c] + 64'd1);
    endtask

    // Small intervals around the per-round clock advance, across the wrap
    task automatic test_random_moderate();
        set_interval(TS_W'($urandom_range(0, 200)));
        wall_ts = 64'hFFFF_FFFF_FFFF_F800;
        run_mix(300, 15);
    endtask

    // Zero interval, no idling on either side
    task automatic test_back_to_back();
        set_interval('0);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        run_mix(200, 7);
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Wider intervals and larger clock steps
    task automatic test_random_wide();
        set_interval(TS_W'($urandom_range(100, 600)));
        run_mix(300, 31);
    endtask

    // Random full-width interval; mostly noise timestamps get through
    task automatic test_random_huge();
        set_interval({$urandom, $urandom});
        run_mix(100, 1000);
    endtask

    // Hold the output for a long stretch while words keep coming
    task automatic test_backpressure();
        set_interval(64'd40);
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        run_mix(40, 15);
        idle_sender();
        wait (!rx_hold_req);
        wait_drain();
        tx_idle_en = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_MARK;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        rx_hold_req = 1'b0;
        wall_ts     = '0;
        err_count   = 0;
        n_items     = 0;
        n_polls     = 0;
        n_irq       = 0;
        n_quiet     = 0;
        n_cfg       = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_max_interval();
        test_unit_interval();
        test_random_moderate();
        test_back_to_back();
        test_random_wide();
        test_random_huge();
        test_backpressure();

        idle_sender();
        wait_drain();
        repeat (8) @(posedge aclk);

        $display("Run: %0d words (%0d polls), %0d interrupts raised, %0d held back by interval",
                 n_items, n_polls, n_irq, n_quiet);
        $display("Run: %0d interval writes incl. zero and full scale, %0d-cycle output hold",
                 n_cfg, HOLD_CYCLES);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
